[rtl/spr_pkg.sv]
`default_nettype none

package spr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int HOLD_CAP    = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;

    // Configuration register indexes.
    localparam logic CFG_PATTERN_BYTES  = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic load;     // take the input request
        logic emit;     // move the oldest held byte toward the output
        logic drop;     // discard a complete match
        logic finish;   // close the current item
    } spr_cmd_t;

    typedef struct packed {
        logic in_appends;  // incoming request carries a byte that will be held
        logic in_end;      // incoming request ends the string
        logic empty;       // nothing held
        logic prefix_ok;   // held bytes agree with the pattern prefix
        logic full;        // enough bytes held for a complete match
        logic pend_valid;  // a result waits for its last flag
        logic out_free;    // output register may be loaded this cycle
        logic end_flag;    // current item ends the string
    } spr_status_t;

endpackage

`default_nettype wire

[rtl/spr_ctrl.sv]
`default_nettype none

module spr_ctrl
    import spr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire spr_status_t status,
    output spr_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;
    logic   can_emit;
    logic   need_push;

    // Emitting a byte pushes any waiting result into the output register.
    assign can_emit  = !status.pend_valid || status.out_free;
    assign need_push = status.pend_valid || status.end_flag;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load = 1'b1;
                    if (status.in_appends)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (status.in_end)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.empty || (status.prefix_ok && !status.full))
                begin
                    state_next = status.end_flag ? S_FLUSH : S_FINISH;
                end
                else if (status.prefix_ok)
                begin
                    cmd.drop = 1'b1;
                end
                else if (can_emit)
                begin
                    cmd.emit = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (status.empty)
                begin
                    state_next = S_FINISH;
                end
                else if (can_emit)
                begin
                    cmd.emit = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!need_push || status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall_next = (state_next != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

`default_nettype wire

[rtl/spr_datapath.sv]
`default_nettype none

module spr_datapath
    import spr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        string_end,
    input  wire spr_cmd_t    cmd,
    output spr_status_t      status,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_present,
    output logic             out_string_end,
    output logic             run_last
);

    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [7:0]  held_reg [8];
    logic [7:0]  held_next [8];
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic        end_flag_reg;
    logic        pend_valid_reg;
    logic [7:0]  pend_byte_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_present_reg;
    logic        out_end_reg;
    logic        out_last_reg;

    logic [3:0]  plen;
    logic [3:0]  cmp_len;
    logic [7:0]  lane_ok;
    logic [3:0]  shamt;
    logic        out_free;
    logic        in_appends;

    assign plen = (pattern_length_reg > 4'(HOLD_CAP)) ? 4'(HOLD_CAP) : pattern_length_reg;
    assign cmp_len = (count_reg < plen) ? count_reg : plen;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_appends = byte_present && (count_reg < 4'd8);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lane_ok[i] = (4'(i) >= cmp_len) ||
                         (held_reg[i] == pattern_bytes_reg[i*8 +: 8]);
        end
    end

    assign status.in_appends = in_appends;
    assign status.in_end     = string_end;
    assign status.empty      = (count_reg == 4'd0);
    // A zero-length pattern never matches, so every byte is emitted.
    assign status.prefix_ok  = (plen != 4'd0) && (&lane_ok);
    assign status.full       = (count_reg >= plen);
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.end_flag   = end_flag_reg;

    assign shamt = cmd.emit ? 4'd1 : plen;

    always_comb
    begin
        logic [4:0] src;
        src        = '0;
        count_next = count_reg;
        for (int i = 0; i < 8; i++)
        begin
            held_next[i] = held_reg[i];
        end
        if (cmd.load && in_appends)
        begin
            held_next[count_reg[2:0]] = data_byte;
            count_next                = count_reg + 4'd1;
        end
        else if (cmd.emit || cmd.drop)
        begin
            for (int i = 0; i < 8; i++)
            begin
                src = 5'(i) + {1'b0, shamt};
                if (src < 5'd8)
                begin
                    held_next[i] = held_reg[src[2:0]];
                end
            end
            count_next = (count_reg > shamt) ? (count_reg - shamt) : 4'd0;
        end
        else if (cmd.finish && end_flag_reg)
        begin
            count_next = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            held_reg[i] <= held_next[i];
        end
        if (cmd.emit)
        begin
            pend_byte_reg <= held_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            count_reg          <= '0;
            end_flag_reg       <= 1'b0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                    CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[3:0];
                    default:            pattern_bytes_reg  <= pattern_bytes_reg;
                endcase
            end
            count_reg <= count_next;
            if (cmd.load)
            begin
                end_flag_reg <= string_end;
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.emit && pend_valid_reg) ||
                (cmd.finish && (pend_valid_reg || end_flag_reg)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: a result only learns it is the last of its item once the
    // following step is known, so each byte waits one step in the pending slot.
    always_ff @(posedge clk)
    begin
        if (cmd.emit && pend_valid_reg)
        begin
            out_byte_reg    <= pend_byte_reg;
            out_present_reg <= 1'b1;
            out_end_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else if (cmd.finish && pend_valid_reg)
        begin
            out_byte_reg    <= pend_byte_reg;
            out_present_reg <= 1'b1;
            out_end_reg     <= end_flag_reg;
            out_last_reg    <= 1'b1;
        end
        else if (cmd.finish && end_flag_reg)
        begin
            out_byte_reg    <= 8'd0;
            out_present_reg <= 1'b0;
            out_end_reg     <= 1'b1;
            out_last_reg    <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_present    = out_present_reg;
    assign out_string_end = out_end_reg;
    assign run_last       = out_last_reg;

endmodule

`default_nettype wire

[rtl/stream_pattern_remover_unit.sv]
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  data_byte, byte_present, string_end
// out      out_valid/out_stall  out_byte, out_present, out_string_end, run_last
// cfg      cfg_valid/cfg_ready  cfg_index (0 pattern_bytes, 1 pattern_length), cfg_data
//
// A request is loaded; the scan then emits the oldest held byte or drops a
// complete match at each step until nothing is held or only a pattern prefix
// remains; at string end a flush emits the rest, and a finish step closes the
// item. A request that adds no held byte and does not end the string is only loaded.
// Reset clears the held count, the pattern registers and the output valid.
// A stalled output holds the controller only when a new result must be pushed.

module stream_pattern_remover_unit
    import spr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        string_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_present,
    output logic             out_string_end,
    output logic             run_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    spr_cmd_t    cmd;
    spr_status_t status;

    assign cfg_ready = 1'b1;

    spr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    spr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .string_end     (string_end),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_present    (out_present),
        .out_string_end (out_string_end),
        .run_last       (run_last)
    );

endmodule

`default_nettype wire
